// ===== sv/lcgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgs_pkg
// Shared types and constants for the LCG seed table search block.
// ----------------------------------------------------------------------------
package lcgs_pkg;

  localparam int SEED_W    = 32;
  localparam int OFFS_W    = 16;
  localparam int ADV_W     = 22;
  localparam int REL_W     = 23;
  localparam int STAT_W    = 3;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_LOADED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_HIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_HIT       = 3'd3;
  localparam logic [STAT_W-1:0] ST_PAST      = 3'd4;
  localparam logic [STAT_W-1:0] ST_RESTARTED = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADV_LIMIT  = 2'd2;

  // generator x' = x * MUL + ADD mod 2^32
  localparam logic [SEED_W-1:0] LCG_MUL = 32'd214013;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd2531011;

  localparam logic [SEED_W-1:0] START_SEED_RST = 32'd0;
  localparam logic [OFFS_W-1:0] ADV_OFFSET_RST = 16'd548;
  localparam logic [ADV_W-1:0]  ADV_LIMIT_RST  = 22'd200000;

  typedef struct packed {
    logic [SEED_W-1:0] start_seed;
    logic [OFFS_W-1:0] adv_offset;
    logic [ADV_W-1:0]  adv_limit;
  } cfg_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [REL_W-1:0]  relative_advance;
    logic [SEED_W-1:0] found_seed;
  } res_t;

endpackage

// ===== sv/lcgs_ram.sv =====
// ----------------------------------------------------------------------------
// lcgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/lcgs_seq.sv =====
// ----------------------------------------------------------------------------
// lcgs_seq
// Sequencer: binary search over the sorted table through one RAM read port,
// insertion shift for loads, and the generator advance.
// ----------------------------------------------------------------------------
module lcgs_seq #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lcgs_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcgs_pkg::MODE_W-1:0]      in_mode,
  input  logic [lcgs_pkg::SEED_W-1:0]      in_seed,
  output logic                             res_valid,
  input  logic                             res_ready,
  output lcgs_pkg::res_t                   res,
  output logic                             ram_we,
  output logic [$clog2(TABLE_DEPTH)-1:0]   ram_waddr,
  output logic [lcgs_pkg::SEED_W-1:0]      ram_wdata,
  output logic                             ram_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]   ram_raddr,
  input  logic [lcgs_pkg::SEED_W-1:0]      ram_rdata
);
  import lcgs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SEARCH   = 3'd1;
  localparam logic [2:0] S_CMP      = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_ADV      = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]        state;
  logic [MODE_W-1:0] mode;
  logic [SEED_W-1:0] key;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     k;
  logic              hit;
  logic [CW-1:0]     count;
  logic [SEED_W-1:0] gen;
  logic [ADV_W-1:0]  adv;

  logic [CW-1:0]     span;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     km1;
  logic              lo_lt_hi;
  logic              k_gt_lo;
  logic [SEED_W-1:0] gen_mul;

  assign span     = hi - lo;
  assign mid      = lo + (span >> 1);
  assign km1      = k - CW'(1);
  assign lo_lt_hi = (lo < hi);
  assign k_gt_lo  = (k > lo);
  assign gen_mul  = gen * LCG_MUL;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // all addresses stay at or below count, which is below the depth while in use
  always_comb begin
    ram_re    = ((state == S_SEARCH) && lo_lt_hi) || ((state == S_SHIFT) && k_gt_lo);
    ram_raddr = (state == S_SHIFT) ? km1[AW-1:0] : mid[AW-1:0];
    ram_we    = (state == S_SHIFT_WR) || ((state == S_SHIFT) && !k_gt_lo);
    ram_waddr = (state == S_SHIFT_WR) ? k[AW-1:0] : lo[AW-1:0];
    ram_wdata = (state == S_SHIFT_WR) ? ram_rdata : key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      gen   <= START_SEED_RST;
      adv   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode <= in_mode;
            key  <= (in_mode == MODE_LOAD) ? in_seed : gen;
            lo   <= '0;
            hi   <= count;
            hit  <= 1'b0;
            res.relative_advance <= '0;
            res.found_seed       <= '0;
            case (in_mode)
              MODE_LOAD: begin
                if (count == DEPTH_C) begin
                  res.status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_SEARCH;
                end
              end
              MODE_STEP: begin
                if (adv >= cfg.adv_limit) begin
                  res.status <= ST_PAST;
                  state      <= S_DONE;
                end else begin
                  state <= S_SEARCH;
                end
              end
              MODE_RESTART: begin
                gen        <= cfg.start_seed;
                adv        <= '0;
                res.status <= ST_RESTARTED;
                state      <= S_DONE;
              end
              default: begin
                count      <= '0;
                res.status <= ST_CLEARED;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (lo_lt_hi) begin
            state <= S_CMP;
          end else if (mode == MODE_LOAD) begin
            k     <= count;
            state <= S_SHIFT;
          end else begin
            // hit tracks the entry last taken as upper bound, i.e. at lo
            res.found_seed <= key;
            res.status     <= hit ? ST_HIT : ST_NO_HIT;
            if (hit) begin
              res.relative_advance <= {1'b0, adv} - {{(REL_W-OFFS_W){1'b0}}, cfg.adv_offset};
            end
            state <= S_ADV;
          end
        end
        S_CMP: begin
          if (ram_rdata < key) begin
            lo <= mid + CW'(1);
          end else begin
            hi  <= mid;
            hit <= (ram_rdata == key);
          end
          state <= S_SEARCH;
        end
        S_SHIFT: begin
          if (k_gt_lo) begin
            state <= S_SHIFT_WR;
          end else begin
            count      <= count + CW'(1);
            res.status <= ST_LOADED;
            state      <= S_DONE;
          end
        end
        S_SHIFT_WR: begin
          k     <= km1;
          state <= S_SHIFT;
        end
        S_ADV: begin
          gen   <= gen_mul + LCG_ADD;
          adv   <= adv + ADV_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/lcg_seed_table_search.sv =====
// ----------------------------------------------------------------------------
// lcg_seed_table_search
// Sorted seed table with insertion loads, searched by binary search for the
// states of a 32-bit LCG (x * 214013 + 2531011).
// ----------------------------------------------------------------------------
//  channel   dir  handshake                contents
//  s_axis    in   s_axis_tvalid/tready     tuser: mode, tdata: seed_value
//  m_axis    out  m_axis_tvalid/tready     tdata: status, rel. advance, seed
//  cfg       in   cfg_valid/cfg_ready      cfg_index, cfg_data
//
//  One item at a time; s_axis_tready is high only while the sequencer idles.
//  Step: per binary search probe a RAM read and a compare, then the
//  generator advance. Load: the same search, plus a read and a write per
//  entry moved up. Other beats go straight to the result.
//  A finished result waits in the sequencer until the output register frees.
//  Reset is synchronous; no clearing pass (count bounds every read).
// ----------------------------------------------------------------------------
module lcg_seed_table_search #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [31:0]                         s_axis_tdata,  // [31:0] seed_value
  input  logic [1:0]                          s_axis_tuser,  // [1:0] mode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] status, [25:3] relative_advance, [57:26] found_seed, [63:58] zero
  output logic [63:0]                         m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcgs_pkg::CFG_DAT_W-1:0]      cfg_data
);
  import lcgs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  cfg_t              cfg;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SEED_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [SEED_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_seed <= START_SEED_RST;
      cfg.adv_offset <= ADV_OFFSET_RST;
      cfg.adv_limit  <= ADV_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_START_SEED: cfg.start_seed <= cfg_data[SEED_W-1:0];
        CFG_ADV_OFFSET: cfg.adv_offset <= cfg_data[OFFS_W-1:0];
        CFG_ADV_LIMIT:  cfg.adv_limit  <= cfg_data[ADV_W-1:0];
        default: ;
      endcase
    end
  end

  lcgs_ram #(
    .WIDTH (SEED_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lcgs_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_seed   (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_axis_tdata <= {6'b0, res.found_seed, res.relative_advance, res.status};
    end
  end

endmodule

// ===== sv/lcgs_checker.sv =====
// ----------------------------------------------------------------------------
// lcgs_checker
// Port-level checks for lcg_seed_table_search, bound to the top level.
// ----------------------------------------------------------------------------
module lcgs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  import lcgs_pkg::*;

  logic [STAT_W-1:0] status;
  logic [REL_W-1:0]  rel;
  logic [SEED_W-1:0] found;

  assign status = m_axis_tdata[2:0];
  assign rel    = m_axis_tdata[25:3];
  assign found  = m_axis_tdata[57:26];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> status != 3'd7)
    else $error("undefined status code");

  a_rel: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status != ST_HIT |-> rel == '0)
    else $error("relative advance set without a hit");

  a_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && status != ST_HIT && status != ST_NO_HIT |-> found == '0)
    else $error("found seed set on a beat that did not search");

endmodule

bind lcg_seed_table_search lcgs_checker u_lcgs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
